@@ design/rsi_pkg.sv @@
// Shared widths, constants and sideband types of the ray/sphere intersection pipeline.
package rsi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 32;
    localparam int A_W       = 64;             // B.B
    localparam int H_W       = 66;             // B.D
    localparam int C_W       = 67;             // D.D - r*r
    localparam int S_W       = 67;             // root of the quarter discriminant
    localparam int Q_W       = 2 * S_W;        // quarter discriminant
    localparam int N_W       = 68;             // signed numerator -h - s
    localparam int MAG_W     = N_W - 1;        // its magnitude
    localparam int M_W       = MAG_W + FRAC_BITS;
    localparam int DIV_STEPS = 32;

    localparam logic [IN_W-2:0] RADIUS_RESET = (IN_W-1)'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [H_W-1:0] h;
        logic [A_W-1:0]        a;
        logic                  degen;
        logic                  q_neg;
        logic                  q_zero;
    } rsi_side_t;

endpackage

@@ design/rsi_sqrt_pipe.sv @@
// Pipelined integer square root, one root bit per stage, with a sideband carried alongside.
module rsi_sqrt_pipe
    import rsi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  logic [Q_W-1:0]   radicand,
    input  rsi_side_t        in_side,
    output logic             out_vld,
    output logic [S_W-1:0]   root,
    output rsi_side_t        out_side
);

    localparam int R_W = S_W + 2;

    logic [Q_W-1:0] rad_reg  [S_W];
    logic [R_W-1:0] rem_reg  [S_W];
    logic [S_W-1:0] root_reg [S_W];
    rsi_side_t      side_reg [S_W];
    logic [S_W-1:0] vld_reg;

    logic [Q_W-1:0] rad_next  [S_W];
    logic [R_W-1:0] rem_next  [S_W];
    logic [S_W-1:0] root_next [S_W];
    rsi_side_t      side_next [S_W];
    logic [S_W-1:0] vld_next;

    for (genvar j = 0; j < S_W; j++) begin : g_stage
        logic [Q_W-1:0] rad_in;
        logic [R_W-1:0] rem_in;
        logic [S_W-1:0] root_in;
        rsi_side_t      side_in;
        logic           vld_in;
        logic [R_W-1:0] rem_sh;
        logic [R_W-1:0] trial;
        logic           fits;

        if (j == 0) begin : g_first
            assign rad_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
            assign vld_in  = in_vld;
        end else begin : g_rest
            assign rad_in  = rad_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign side_in = side_reg[j-1];
            assign vld_in  = vld_reg[j-1];
        end

        // Bring down the next two radicand bits and try the root bit as one.
        assign rem_sh = {rem_in[R_W-3:0], rad_in[Q_W-1-2*j -: 2]};
        assign trial  = {root_in, 2'b01};
        assign fits   = rem_sh >= trial;

        assign rad_next[j]  = rad_in;
        assign rem_next[j]  = fits ? (rem_sh - trial) : rem_sh;
        assign root_next[j] = {root_in[S_W-2:0], fits};
        assign side_next[j] = side_in;
        assign vld_next[j]  = vld_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < S_W; j++)
            begin
                rad_reg[j]  <= rad_next[j];
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
                side_reg[j] <= side_next[j];
            end
        end
    end

    assign out_vld  = vld_reg[S_W-1];
    assign root     = root_reg[S_W-1];
    assign out_side = side_reg[S_W-1];

endmodule

@@ design/ray_sphere_intersect.sv @@
// Top level of the ray/sphere intersection pipeline with its configuration registers.
// Stages from an accepted input beat to its result beat: 6 arithmetic stages,
// 67 square root stages at one root bit each, 2 numerator stages, 32 divider stages, output.
// Throughput: one ray per cycle unless stalled; every stage is a register stage, all move as one.
// A stalled output holds the pipe; in_stall rises only while a result waits in the output.
// Reset (rst_n, asynchronous, active low) clears all valid bits, center to 0, radius to 1.0.
module ray_sphere_intersect
    import rsi_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic signed [IN_W-1:0] start_x,
    input  logic signed [IN_W-1:0] start_y,
    input  logic signed [IN_W-1:0] start_z,
    input  logic signed [IN_W-1:0] dir_x,
    input  logic signed [IN_W-1:0] dir_y,
    input  logic signed [IN_W-1:0] dir_z,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [IN_W-1:0] ray_param,
    output logic [1:0]             contact_kind,
    output logic                   hit_status,
    output logic                   degenerate,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [IN_W-1:0]        cfg_data
);

    typedef enum logic [1:0] {
        KIND_MISS  = 2'd0,
        KIND_TOUCH = 2'd1,
        KIND_CROSS = 2'd2
    } contact_t;

    typedef struct packed {
        contact_t kind;
        logic     status;
        logic     degen;
        logic     use_div;
    } rsi_flags_t;

    localparam logic [1:0] CFG_CENTER_X = 2'd0;
    localparam logic [1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [1:0] CFG_CENTER_Z = 2'd2;
    localparam logic [1:0] CFG_RADIUS   = 2'd3;

    localparam logic signed [IN_W-1:0] PARAM_MAX = {1'b0, {(IN_W-1){1'b1}}};
    localparam logic signed [IN_W-1:0] PARAM_MIN = {1'b1, {(IN_W-1){1'b0}}};

    // Configuration registers. Writes are always taken.
    logic signed [IN_W-1:0] center_reg [3];
    logic [IN_W-2:0]        radius_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            radius_reg    <= RADIUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CENTER_X: center_reg[0] <= cfg_data;
                CFG_CENTER_Y: center_reg[1] <= cfg_data;
                CFG_CENTER_Z: center_reg[2] <= cfg_data;
                CFG_RADIUS:   radius_reg    <= cfg_data[IN_W-2:0];
                default:      radius_reg    <= radius_reg;
            endcase
        end
    end

    // The whole pipe advances together unless a finished result is held by the consumer.
    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    logic signed [IN_W-1:0] start_v [3];
    logic signed [IN_W-1:0] dir_v   [3];

    assign start_v[0] = start_x;
    assign start_v[1] = start_y;
    assign start_v[2] = start_z;
    assign dir_v[0]   = dir_x;
    assign dir_v[1]   = dir_y;
    assign dir_v[2]   = dir_z;

    // Valid bits of the front stages.
    logic [5:0] fv_reg;

    // Stage 1: direction B and offset D = A - C.
    logic signed [IN_W-1:0] s1_b_reg [3];
    logic signed [IN_W:0]   s1_d_reg [3];

    // Stage 2: the component products.
    logic [A_W-1:0]        s2_bb_reg [3];
    logic signed [A_W:0]   s2_bd_reg [3];
    logic [A_W:0]          s2_dd_reg [3];
    logic [2*IN_W-3:0]     s2_rr_reg;

    // Stage 3: a, h and c.
    logic [A_W-1:0]        s3_a_reg;
    logic signed [H_W-1:0] s3_h_reg;
    logic signed [C_W-1:0] s3_c_reg;

    // Stage 4: partial products of h*h and a*c, each within a 34 by 34 multiplier.
    logic [A_W-1:0]        s4_a_reg;
    logic signed [H_W-1:0] s4_h_reg;
    logic                  s4_degen_reg;
    logic [65:0]           s4_hll_reg;
    logic signed [66:0]    s4_hlh_reg;
    logic signed [65:0]    s4_hhh_reg;
    logic [64:0]           s4_all_reg;
    logic [64:0]           s4_ahl_reg;
    logic signed [66:0]    s4_alh_reg;
    logic signed [66:0]    s4_ahh_reg;

    // Stage 5: h*h and a*c.
    logic [A_W-1:0]        s5_a_reg;
    logic signed [H_W-1:0] s5_h_reg;
    logic                  s5_degen_reg;
    logic signed [Q_W-1:0] s5_hsq_reg;
    logic signed [Q_W-1:0] s5_ac_reg;

    // Stage 6: q = h*h - a*c, a quarter of the discriminant.
    logic [A_W-1:0]        s6_a_reg;
    logic signed [H_W-1:0] s6_h_reg;
    logic                  s6_degen_reg;
    logic signed [Q_W-1:0] s6_q_reg;

    logic signed [H_W-1:0] hl_s;
    logic [32:0]           hl;
    logic signed [32:0]    hh_s;
    logic [31:0]           al;
    logic [31:0]           ah;
    logic [32:0]           cl;
    logic signed [33:0]    ch_s;

    assign hl_s = s3_h_reg;
    assign hl   = hl_s[32:0];
    assign hh_s = hl_s[H_W-1:33];
    assign al   = s3_a_reg[31:0];
    assign ah   = s3_a_reg[A_W-1:32];
    assign cl   = s3_c_reg[32:0];
    assign ch_s = s3_c_reg[C_W-1:33];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else if (adv)
        begin
            fv_reg <= {fv_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_b_reg[i]  <= dir_v[i];
                s1_d_reg[i]  <= (IN_W+1)'(start_v[i]) - (IN_W+1)'(center_reg[i]);
                // Both squares are evaluated at the full width of their registers.
                s2_bb_reg[i] <= s1_b_reg[i] * s1_b_reg[i];
                s2_bd_reg[i] <= s1_b_reg[i] * s1_d_reg[i];
                s2_dd_reg[i] <= s1_d_reg[i] * s1_d_reg[i];
            end
            s2_rr_reg <= radius_reg * radius_reg;

            s3_a_reg <= s2_bb_reg[0] + s2_bb_reg[1] + s2_bb_reg[2];
            s3_h_reg <= H_W'(s2_bd_reg[0]) + H_W'(s2_bd_reg[1]) + H_W'(s2_bd_reg[2]);
            s3_c_reg <= $signed(C_W'(s2_dd_reg[0]) + C_W'(s2_dd_reg[1])
                                + C_W'(s2_dd_reg[2]) - C_W'(s2_rr_reg));

            s4_a_reg     <= s3_a_reg;
            s4_h_reg     <= s3_h_reg;
            s4_degen_reg <= (s3_a_reg == '0);
            s4_hll_reg   <= hl * hl;
            s4_hlh_reg   <= $signed({1'b0, hl}) * hh_s;
            s4_hhh_reg   <= hh_s * hh_s;
            s4_all_reg   <= al * cl;
            s4_ahl_reg   <= ah * cl;
            s4_alh_reg   <= $signed({1'b0, al}) * ch_s;
            s4_ahh_reg   <= $signed({1'b0, ah}) * ch_s;

            s5_a_reg     <= s4_a_reg;
            s5_h_reg     <= s4_h_reg;
            s5_degen_reg <= s4_degen_reg;
            // The cross term of h*h appears twice, hence the extra shift.
            s5_hsq_reg   <= (Q_W'(s4_hhh_reg) <<< 66) + (Q_W'(s4_hlh_reg) <<< 34)
                            + Q_W'(s4_hll_reg);
            s5_ac_reg    <= (Q_W'(s4_ahh_reg) <<< 65) + (Q_W'(s4_alh_reg) <<< 33)
                            + (Q_W'(s4_ahl_reg) << 32) + Q_W'(s4_all_reg);

            s6_a_reg     <= s5_a_reg;
            s6_h_reg     <= s5_h_reg;
            s6_degen_reg <= s5_degen_reg;
            s6_q_reg     <= s5_hsq_reg - s5_ac_reg;
        end
    end

    // Square root of q. Only meaningful for positive q; the sign and zero flags ride along.
    rsi_side_t        sq_in_side;
    rsi_side_t        sq_out_side;
    logic             sq_out_vld;
    logic [S_W-1:0]   sq_root;

    assign sq_in_side.h      = s6_h_reg;
    assign sq_in_side.a      = s6_a_reg;
    assign sq_in_side.degen  = s6_degen_reg;
    assign sq_in_side.q_neg  = s6_q_reg[Q_W-1];
    assign sq_in_side.q_zero = (s6_q_reg == '0);

    rsi_sqrt_pipe u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (fv_reg[5]),
        .radicand (s6_q_reg),
        .in_side  (sq_in_side),
        .out_vld  (sq_out_vld),
        .root     (sq_root),
        .out_side (sq_out_side)
    );

    // Stage 7: near root numerator n1 = -h - s and the hit decision. At a touch s is zero,
    // so n1 is also the touch numerator.
    logic signed [N_W-1:0] neg_h;
    logic signed [N_W-1:0] root_s;
    logic signed [N_W-1:0] n1;
    logic signed [N_W-1:0] n2;
    rsi_flags_t            fl_next;

    assign neg_h  = -N_W'(sq_out_side.h);
    assign root_s = $signed({1'b0, sq_root});
    assign n1     = neg_h - root_s;
    assign n2     = neg_h + root_s;

    always_comb
    begin
        fl_next.kind    = KIND_MISS;
        fl_next.status  = 1'b0;
        fl_next.degen   = sq_out_side.degen;
        fl_next.use_div = 1'b0;
        if (sq_out_side.degen || sq_out_side.q_neg)
        begin
            fl_next.kind = KIND_MISS;
        end
        else if (sq_out_side.q_zero)
        begin
            fl_next.kind    = KIND_TOUCH;
            fl_next.use_div = 1'b1;
            fl_next.status  = (neg_h > 0);
        end
        else
        begin
            // The far root reaches t = 1 exactly when n2 >= a.
            fl_next.kind    = KIND_CROSS;
            fl_next.status  = (n2 >= $signed(N_W'(sq_out_side.a)));
            fl_next.use_div = fl_next.status;
        end
    end

    logic                  s7_valid_reg;
    logic signed [N_W-1:0] s7_n_reg;
    logic [A_W-1:0]        s7_a_reg;
    rsi_flags_t            s7_fl_reg;

    // Stage 8: magnitude of the scaled numerator and the quotient overflow check.
    logic [MAG_W-1:0]      mag;
    logic [M_W-1:0]        m_full;
    logic [M_W-33:0]       m_hi;
    logic                  ovf;

    assign mag    = s7_n_reg[N_W-1] ? MAG_W'(-s7_n_reg) : MAG_W'(s7_n_reg);
    assign m_full = {mag, {FRAC_BITS{1'b0}}};
    assign m_hi   = m_full[M_W-1:32];
    assign ovf    = A_W'(m_hi) >= s7_a_reg;

    // Divider stages: index 0 is the stage 8 register, each later index yields one
    // quotient bit, most significant first.
    logic [DIV_STEPS:0] dv_reg;
    logic [A_W-1:0]     drem_reg [DIV_STEPS+1];
    logic [31:0]        dquo_reg [DIV_STEPS+1];
    logic [31:0]        dlo_reg  [DIV_STEPS+1];
    logic [A_W-1:0]     da_reg   [DIV_STEPS+1];
    logic               dneg_reg [DIV_STEPS+1];
    logic               dovf_reg [DIV_STEPS+1];
    rsi_flags_t         dfl_reg  [DIV_STEPS+1];

    logic [A_W-1:0]     drem_next [DIV_STEPS];
    logic [31:0]        dquo_next [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [A_W:0] rs;
        logic         ge;
        assign rs           = {drem_reg[k], dlo_reg[k][DIV_STEPS-1-k]};
        assign ge           = rs >= {1'b0, da_reg[k]};
        assign drem_next[k] = ge ? A_W'(rs - {1'b0, da_reg[k]}) : A_W'(rs);
        assign dquo_next[k] = {dquo_reg[k][30:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg <= 1'b0;
            dv_reg       <= '0;
        end
        else if (adv)
        begin
            s7_valid_reg <= sq_out_vld;
            dv_reg       <= {dv_reg[DIV_STEPS-1:0], s7_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_n_reg  <= n1;
            s7_a_reg  <= sq_out_side.a;
            s7_fl_reg <= fl_next;

            // On overflow the quotient is not used, so the divider starts from zero.
            drem_reg[0] <= ovf ? '0 : A_W'(m_hi);
            dquo_reg[0] <= '0;
            dlo_reg[0]  <= m_full[31:0];
            da_reg[0]   <= s7_a_reg;
            dneg_reg[0] <= s7_n_reg[N_W-1];
            dovf_reg[0] <= ovf;
            dfl_reg[0]  <= s7_fl_reg;

            for (int k = 0; k < DIV_STEPS; k++)
            begin
                drem_reg[k+1] <= drem_next[k];
                dquo_reg[k+1] <= dquo_next[k];
                dlo_reg[k+1]  <= dlo_reg[k];
                da_reg[k+1]   <= da_reg[k];
                dneg_reg[k+1] <= dneg_reg[k];
                dovf_reg[k+1] <= dovf_reg[k];
                dfl_reg[k+1]  <= dfl_reg[k];
            end
        end
    end

    // Output stage: floor toward minus infinity for negative numerators, then saturation.
    logic [31:0]            fq;
    logic [32:0]            fmag;
    logic signed [IN_W-1:0] param_next;
    rsi_flags_t             ffl;

    assign fq   = dquo_reg[DIV_STEPS];
    assign ffl  = dfl_reg[DIV_STEPS];
    assign fmag = {1'b0, fq} + 33'(drem_reg[DIV_STEPS] != '0);

    always_comb
    begin
        param_next = PARAM_MAX;
        if (!ffl.use_div)
        begin
            param_next = PARAM_MAX;
        end
        else if (!dneg_reg[DIV_STEPS])
        begin
            param_next = (dovf_reg[DIV_STEPS] || fq[31]) ? PARAM_MAX : $signed(fq);
        end
        else if (dovf_reg[DIV_STEPS] || (fmag > 33'h0_8000_0000))
        begin
            param_next = PARAM_MIN;
        end
        else
        begin
            param_next = $signed(~fmag[31:0] + 32'd1);
        end
    end

    logic signed [IN_W-1:0] ray_param_reg;
    logic [1:0]             kind_reg;
    logic                   status_reg;
    logic                   degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ray_param_reg <= param_next;
            kind_reg      <= ffl.kind;
            status_reg    <= ffl.status;
            degen_reg     <= ffl.degen;
        end
    end

    assign out_valid    = out_valid_reg;
    assign ray_param    = ray_param_reg;
    assign contact_kind = kind_reg;
    assign hit_status   = status_reg;
    assign degenerate   = degen_reg;

endmodule

@@ tb/rsi_tb_pkg.sv @@
// Register indexes, contact codes and the ray beat type shared by the testbench files.
`timescale 1ns / 1ps
package rsi_tb_pkg;

    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } cfg_reg_e;

    typedef enum logic [1:0] {
        CONTACT_MISS  = 2'd0,
        CONTACT_TOUCH = 2'd1,
        CONTACT_CROSS = 2'd2
    } contact_e;

    typedef struct {
        logic signed [31:0] sx, sy, sz;
        logic signed [31:0] bx, by, bz;
    } ray_t;

    localparam int PIPE_LATENCY = 108;

endpackage

@@ tb/rsi_checker.sv @@
// Channel monitor, hit predictor and result comparison for the ray/sphere block.
`timescale 1ns / 1ps
module rsi_checker
    import rsi_pkg::*;
    import rsi_tb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic signed [IN_W-1:0] start_x,
    input  logic signed [IN_W-1:0] start_y,
    input  logic signed [IN_W-1:0] start_z,
    input  logic signed [IN_W-1:0] dir_x,
    input  logic signed [IN_W-1:0] dir_y,
    input  logic signed [IN_W-1:0] dir_z,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic signed [IN_W-1:0] ray_param,
    input  logic [1:0]             contact_kind,
    input  logic                   hit_status,
    input  logic                   degenerate,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [IN_W-1:0]        cfg_data,
    output int                     fail_count,
    output int                     pending
);

    typedef logic signed [271:0] wint_t;

    typedef struct {
        logic signed [31:0] param;
        logic [1:0]         kind;
        logic               status;
        logic               degen;
    } hit_t;

    localparam logic signed [31:0] PARAM_SAT = 32'h7FFF_FFFF;

    logic signed [31:0] ctr_x, ctr_y, ctr_z;
    logic [30:0]        rad;
    hit_t               hits_due[$];

    // Floor division by a positive denominator, clamped to the 32 bit signed range.
    function automatic logic signed [31:0] div_floor_sat(wint_t num, wint_t den);
        wint_t quo;
        quo = num / den;
        if (num < 0 && (num % den) != 0)
            quo = quo - 1;
        if (quo > wint_t'(32'sh7FFF_FFFF))
            return PARAM_SAT;
        if (quo < -wint_t'(64'sh8000_0000))
            return 32'sh8000_0000;
        return quo[31:0];
    endfunction

    function automatic hit_t predict_hit(logic signed [31:0] sx, sy, sz, bx, by, bz);
        hit_t  res;
        wint_t wbx, wby, wbz, dx, dy, dz, a, h, c, q, root, cand, scale, n1, n2;
        wbx = wint_t'(bx);
        wby = wint_t'(by);
        wbz = wint_t'(bz);
        dx = wint_t'(sx) - wint_t'(ctr_x);
        dy = wint_t'(sy) - wint_t'(ctr_y);
        dz = wint_t'(sz) - wint_t'(ctr_z);
        scale = wint_t'(1) <<< FRAC_BITS;
        res.param = PARAM_SAT;
        res.kind = CONTACT_MISS;
        res.status = 1'b0;
        res.degen = 1'b0;
        a = wbx * wbx + wby * wby + wbz * wbz;
        if (a == 0) begin
            res.degen = 1'b1;
            return res;
        end
        h = wbx * dx + wby * dy + wbz * dz;
        c = dx * dx + dy * dy + dz * dz - wint_t'({1'b0, rad}) * wint_t'({1'b0, rad});
        q = h * h - a * c;
        if (q == 0) begin
            // Tangent ray: t is reported even when it lies behind the start point.
            res.kind = CONTACT_TOUCH;
            res.param = div_floor_sat(-h * scale, a);
            res.status = (-h > 0);
        end else if (q > 0) begin
            root = 0;
            for (int k = 67; k >= 0; k--) begin
                cand = root | (wint_t'(1) << k);
                if (cand * cand <= q)
                    root = cand;
            end
            n1 = -h - root;
            n2 = -h + root;
            res.kind = CONTACT_CROSS;
            if (n2 >= a) begin
                res.param = div_floor_sat(n1 * scale, a);
                res.status = 1'b1;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        hit_t got, want;
        int   errs;
        errs = 0;
        if (!rst_n) begin
            ctr_x <= '0;
            ctr_y <= '0;
            ctr_z <= '0;
            rad <= RADIUS_RESET;
            hits_due.delete();
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_e'(cfg_index))
                    REG_CENTER_X: ctr_x <= cfg_data;
                    REG_CENTER_Y: ctr_y <= cfg_data;
                    REG_CENTER_Z: ctr_z <= cfg_data;
                    REG_RADIUS:   rad <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                hits_due.push_back(predict_hit(start_x, start_y, start_z, dir_x, dir_y, dir_z));
            if (out_valid && !out_stall) begin
                got.param = ray_param;
                got.kind = contact_kind;
                got.status = hit_status;
                got.degen = degenerate;
                if (hits_due.size() == 0) begin
                    $error("result beat with no ray outstanding");
                    errs++;
                end else begin
                    want = hits_due.pop_front();
                    if (got.param !== want.param) begin
                        $error("ray_param: expected %0d, got %0d", want.param, got.param);
                        errs++;
                    end
                    if (got.kind !== want.kind) begin
                        $error("contact_kind: expected %0d, got %0d", want.kind, got.kind);
                        errs++;
                    end
                    if (got.status !== want.status) begin
                        $error("hit_status: expected %0d, got %0d", want.status, got.status);
                        errs++;
                    end
                    if (got.degen !== want.degen) begin
                        $error("degenerate: expected %0d, got %0d", want.degen, got.degen);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= hits_due.size();
        end
    end

endmodule

@@ tb/ray_sphere_intersect_tb.sv @@
// Stimulus, handshake pacing and verdict for the ray/sphere intersection block.
`timescale 1ns / 1ps
module ray_sphere_intersect_tb;
    import rsi_pkg::*;
    import rsi_tb_pkg::*;

    // Longest stretch with no beat on any channel before the run is declared hung.
    // The long receiver hold lasts HOLD_CYCLES and the pipe is 108 deep.
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int ONE = 1 << FRAC_BITS;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic signed [IN_W-1:0] start_x, start_y, start_z;
    logic signed [IN_W-1:0] dir_x, dir_y, dir_z;
    logic                   out_valid;
    logic                   out_stall;
    logic signed [IN_W-1:0] ray_param;
    logic [1:0]             contact_kind;
    logic                   hit_status;
    logic                   degenerate;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [1:0]             cfg_index;
    logic [IN_W-1:0]        cfg_data;
    int                     fail_count;
    int                     pending;

    // Pacing controls shared between the stimulus and the receiver process.
    bit quiet;
    bit hold_req;
    int idle_cycles;

    // Shadow of the sphere, used only to aim rays at it.
    logic signed [31:0] cur_cx, cur_cy, cur_cz;
    logic [30:0]        cur_rad;

    ray_sphere_intersect i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .start_x(start_x), .start_y(start_y), .start_z(start_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .ray_param(ray_param), .contact_kind(contact_kind),
        .hit_status(hit_status), .degenerate(degenerate),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    rsi_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .start_x(start_x), .start_y(start_y), .start_z(start_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .ray_param(ray_param), .contact_kind(contact_kind),
        .hit_status(hit_status), .degenerate(degenerate),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // The receiver alternates random stall bursts with runs of free flow. On request it
    // holds off for a long stretch so the pipe fills and the input side backs up.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (quiet || $urandom_range(0, 2) != 0)
            begin
                out_stall <= 1'b0;
                repeat (quiet ? 1 : $urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    end

    // Watchdog: any beat on any channel restarts the count.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Writes one register; the caller makes sure the pipe is empty first.
    task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Reconfigures the sphere once every outstanding ray has come back and the pipe has
    // had time to drain.
    task automatic set_sphere(logic signed [31:0] cx, cy, cz, logic [30:0] r);
        while (pending != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 10) @(posedge clk);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_RADIUS, {1'b0, r});
        cur_cx = cx;
        cur_cy = cy;
        cur_cz = cz;
        cur_rad = r;
    endtask

    // Offers one ray beat, sometimes after a random idle burst, and waits for acceptance.
    // in_valid stays high between back-to-back beats.
    task automatic send_ray(ray_t ray);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        start_x <= ray.sx;
        start_y <= ray.sy;
        start_z <= ray.sz;
        dir_x <= ray.bx;
        dir_y <= ray.by;
        dir_z <= ray.bz;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    function automatic ray_t make_ray(longint sx, sy, sz, bx, by, bz);
        ray_t r;
        r.sx = sx[31:0];
        r.sy = sy[31:0];
        r.sz = sz[31:0];
        r.bx = bx[31:0];
        r.by = by[31:0];
        r.bz = bz[31:0];
        return r;
    endfunction

    function automatic longint rand_span(int span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Random ray: mostly aimed at the current sphere so that hits, tangents and far-root
    // cases show up, the rest small-valued, fully random or with a zero direction.
    function automatic ray_t random_ray();
        int     pick;
        int     sh;
        longint ox, oy, oz, tx, ty, tz, jit;
        ray_t   r;
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            ox = rand_span(32 * ONE);
            oy = rand_span(32 * ONE);
            oz = rand_span(32 * ONE);
            jit = (cur_rad > 31'd0 && cur_rad < 31'h0100_0000) ? longint'(cur_rad) : ONE;
            tx = rand_span(int'(jit)) - ox;
            ty = rand_span(int'(jit)) - oy;
            tz = rand_span(int'(jit)) - oz;
            sh = $urandom_range(0, 10);
            if ($urandom_range(0, 4) == 0)
            begin
                tx = -tx;
                ty = -ty;
                tz = -tz;
            end
            r = make_ray(longint'(cur_cx) + ox, longint'(cur_cy) + oy, longint'(cur_cz) + oz,
                         tx >>> sh, ty >>> sh, tz >>> sh);
        end
        else if (pick < 75)
            r = make_ray(rand_span(16 * ONE), rand_span(16 * ONE), rand_span(16 * ONE),
                         rand_span(4 * ONE), rand_span(4 * ONE), rand_span(4 * ONE));
        else if (pick < 95)
            r = make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            r = make_ray($urandom, $urandom, $urandom, 0, 0, 0);
        return r;
    endfunction

    // Directed rays against the reset sphere (center at the origin, radius 1.0).
    task automatic run_directed();
        longint mn, mx;
        mn = -64'sh8000_0000;
        mx = 64'sh7FFF_FFFF;
        // Tangent ahead of the start point, and tangent behind it.
        send_ray(make_ray(-5 * ONE, ONE, 0, ONE, 0, 0));
        send_ray(make_ray(5 * ONE, ONE, 0, ONE, 0, 0));
        // Tangent with the start exactly on the touch point: t is zero, not a hit.
        send_ray(make_ray(0, ONE, 0, ONE, 0, 0));
        // Two crossings with the far root beyond one, and with both roots below one.
        send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0));
        send_ray(make_ray(-5 * ONE, 0, 0, 100 * ONE, 0, 0));
        // Near root exactly at one.
        send_ray(make_ray(-3 * ONE, 0, 0, 2 * ONE, 0, 0));
        // Start inside the sphere: the near root is negative and still reported.
        send_ray(make_ray(0, 0, 0, 0, ONE, 0));
        // Plain miss and a ray pointing away.
        send_ray(make_ray(-5 * ONE, 3 * ONE, 0, ONE, 0, 0));
        send_ray(make_ray(-5 * ONE, 0, 0, -ONE, 0, 0));
        // Zero direction, from the origin and from an extreme corner.
        send_ray(make_ray(0, 0, 0, 0, 0, 0));
        send_ray(make_ray(mn, mx, mn, 0, 0, 0));
        // Tiny direction from far away: the parameter saturates.
        send_ray(make_ray(-30000 * ONE, 0, 0, 1, 0, 0));
        send_ray(make_ray(30000 * ONE, 0, 0, 1, 0, 0));
        // Field extremes.
        send_ray(make_ray(mn, mn, mn, mn, mn, mn));
        send_ray(make_ray(mx, mx, mx, mx, mx, mx));
        send_ray(make_ray(mn, mx, mn, mx, mn, mx));
        send_ray(make_ray(-1, -1, -1, -1, -1, -1));
        send_ray(make_ray(mx, 0, 0, mn, 0, 0));
        send_ray(make_ray(0, 0, 0, 1, 0, 0));
        send_ray(make_ray(0, 0, 0, 0, 0, -1));
    endtask

    initial
    begin
        logic signed [31:0] pcx, pcy, pcz;
        logic [30:0]        prad;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_CENTER_X;
        cfg_data = '0;
        {start_x, start_y, start_z, dir_x, dir_y, dir_z} = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        idle_cycles = 0;
        cur_cx = '0;
        cur_cy = '0;
        cur_cz = '0;
        cur_rad = RADIUS_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // Seven sphere settings; the last phase runs with no idling on either side.
        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: begin
                    pcx = 32'(rand_span(8 * ONE));
                    pcy = 32'(rand_span(8 * ONE));
                    pcz = 32'(rand_span(8 * ONE));
                    prad = 31'($urandom_range(1, 40 * ONE));
                end
                1: begin
                    pcx = 32'sh8000_0000;
                    pcy = 32'sh8000_0000;
                    pcz = 32'sh8000_0000;
                    prad = 31'h7FFF_FFFF;
                end
                2: begin
                    pcx = 32'sh7FFF_FFFF;
                    pcy = 32'sh7FFF_FFFF;
                    pcz = 32'sh7FFF_FFFF;
                    prad = '0;
                end
                3: begin
                    pcx = $urandom;
                    pcy = $urandom;
                    pcz = $urandom;
                    prad = 31'($urandom);
                end
                5: begin
                    pcx = '0;
                    pcy = '0;
                    pcz = '0;
                    prad = 31'(ONE);
                end
                default: begin
                    pcx = 32'(rand_span(100 * ONE));
                    pcy = 32'(rand_span(100 * ONE));
                    pcz = 32'(rand_span(100 * ONE));
                    prad = 31'($urandom_range(ONE / 4, 20 * ONE));
                end
            endcase
            in_valid <= 1'b0;
            set_sphere(pcx, pcy, pcz, prad);
            if (phase == 6)
                quiet = 1'b1;
            for (int n = 0; n < 225; n++)
            begin
                if (phase == 1 && n == 20)
                    hold_req = 1'b1;
                if (phase == 3 && n == 100)
                begin
                    // Let the pipe run dry before continuing.
                    in_valid <= 1'b0;
                    while (pending != 0) @(posedge clk);
                end
                send_ray(random_ray());
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
